// ----- sv/alu8_pkg.sv -----
package alu8_pkg;

  // Field widths
  localparam int unsigned OpW   = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned BitW  = 3;
  localparam int unsigned FlagW = 4;

  // Flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // BCD adjust constants
  localparam logic [DataW-1:0] DaaHiAdj  = 8'h60;
  localparam logic [DataW-1:0] DaaLoAdj  = 8'h06;
  localparam logic [DataW-1:0] DaaHiLim  = 8'h99;
  localparam logic [3:0]       DaaLoLim  = 4'h9;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SLA  = 5'd14,
    OP_SRA  = 5'd15,
    OP_SWAP = 5'd16,
    OP_SRL  = 5'd17,
    OP_RLCA = 5'd18,
    OP_RRCA = 5'd19,
    OP_RLA  = 5'd20,
    OP_RRA  = 5'd21,
    OP_BIT  = 5'd22,
    OP_RES  = 5'd23,
    OP_SET  = 5'd24,
    OP_DAA  = 5'd25,
    OP_CPL  = 5'd26,
    OP_CCF  = 5'd27,
    OP_SCF  = 5'd28
  } alu_op_e;

  // One operation as it enters the datapath
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] opb;
    logic [BitW-1:0]  bit_idx;
    logic [FlagW-1:0] flags;
  } alu_req_t;

  // One finished result
  typedef struct packed {
    logic [DataW-1:0] result;
    logic [FlagW-1:0] flags;
    logic             wr;
  } alu_res_t;

endpackage

// ----- sv/alu8_core.sv -----
module alu8_core
  import alu8_pkg::*;
(
  input  alu_req_t req_i,
  output alu_res_t res_o
);

  logic [DataW-1:0] a, b, r;
  logic [FlagW-1:0] f, fo;
  logic             c, cin, wr;
  logic [DataW:0]   add_sum, sub_dif;
  logic [4:0]       add_half, sub_half;
  logic [DataW-1:0] sh_in, sh_out, bit_mask;
  logic             sh_cout, daa_c;
  logic [DataW-1:0] daa_t;

  assign a = req_i.acc;
  assign b = req_i.opb;
  assign f = req_i.flags;
  assign c = f[FlagC];
  assign bit_mask = DataW'(1) << req_i.bit_idx;

  // Carry in for adc and sbc only
  assign cin = ((req_i.op == OP_ADC) || (req_i.op == OP_SBC)) ? c : 1'b0;

  // Shared adder and subtractor, with nibble carry and borrow
  assign add_sum  = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
  assign sub_dif  = {1'b0, a} - {1'b0, b} - {{DataW{1'b0}}, cin};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};

  // Shifter: CB forms take operand B, accumulator forms take A
  assign sh_in = (req_i.op inside {[OP_RLCA:OP_RRA]}) ? a : b;

  always_comb begin
    sh_out  = sh_in;
    sh_cout = 1'b0;
    case (req_i.op)
      OP_RLC, OP_RLCA: begin
        sh_out  = {sh_in[DataW-2:0], sh_in[DataW-1]};
        sh_cout = sh_in[DataW-1];
      end
      OP_RRC, OP_RRCA: begin
        sh_out  = {sh_in[0], sh_in[DataW-1:1]};
        sh_cout = sh_in[0];
      end
      OP_RL, OP_RLA: begin
        sh_out  = {sh_in[DataW-2:0], c};
        sh_cout = sh_in[DataW-1];
      end
      OP_RR, OP_RRA: begin
        sh_out  = {c, sh_in[DataW-1:1]};
        sh_cout = sh_in[0];
      end
      OP_SLA: begin
        sh_out  = {sh_in[DataW-2:0], 1'b0};
        sh_cout = sh_in[DataW-1];
      end
      OP_SRA: begin
        sh_out  = {sh_in[DataW-1], sh_in[DataW-1:1]};
        sh_cout = sh_in[0];
      end
      OP_SWAP: begin
        sh_out  = {sh_in[3:0], sh_in[7:4]};
        sh_cout = 1'b0;
      end
      OP_SRL: begin
        sh_out  = {1'b0, sh_in[DataW-1:1]};
        sh_cout = sh_in[0];
      end
      default: begin
        sh_out  = sh_in;
        sh_cout = 1'b0;
      end
    endcase
  end

  // Decimal adjust of the accumulator
  always_comb begin
    daa_t = a;
    daa_c = c;
    if (!f[FlagN]) begin
      if (c || (a > DaaHiLim)) begin
        daa_t = daa_t + DaaHiAdj;
        daa_c = 1'b1;
      end
      if (f[FlagH] || (a[3:0] > DaaLoLim)) begin
        daa_t = daa_t + DaaLoAdj;
      end
    end else begin
      if (c) begin
        daa_t = daa_t - DaaHiAdj;
      end
      if (f[FlagH]) begin
        daa_t = daa_t - DaaLoAdj;
      end
    end
  end

  // Select result, flags and write enable
  always_comb begin
    r  = a;
    fo = f;
    wr = 1'b1;
    case (req_i.op)
      OP_ADD, OP_ADC: begin
        r  = add_sum[DataW-1:0];
        fo = {~|add_sum[DataW-1:0], 1'b0, add_half[4], add_sum[DataW]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r  = sub_dif[DataW-1:0];
        fo = {~|sub_dif[DataW-1:0], 1'b1, sub_half[4], sub_dif[DataW]};
        wr = (req_i.op != OP_CP);
      end
      OP_AND: begin
        r  = a & b;
        fo = {~|(a & b), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r  = a ^ b;
        fo = {~|(a ^ b), 3'b000};
      end
      OP_OR: begin
        r  = a | b;
        fo = {~|(a | b), 3'b000};
      end
      OP_INC: begin
        r  = b + DataW'(1);
        fo = {~|r, 1'b0, &b[3:0], c};
      end
      OP_DEC: begin
        r  = b - DataW'(1);
        fo = {~|r, 1'b1, ~|b[3:0], c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        r  = sh_out;
        fo = {~|sh_out, 2'b00, sh_cout};
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        r  = sh_out;
        fo = {3'b000, sh_cout};
      end
      OP_BIT: begin
        r  = b;
        fo = {~|(b & bit_mask), 1'b0, 1'b1, c};
        wr = 1'b0;
      end
      OP_RES: r = b & ~bit_mask;
      OP_SET: r = b | bit_mask;
      OP_DAA: begin
        r  = daa_t;
        fo = {~|daa_t, f[FlagN], 1'b0, daa_c};
      end
      OP_CPL: begin
        r  = ~a;
        fo = {f[FlagZ], 1'b1, 1'b1, c};
      end
      OP_CCF: fo = {f[FlagZ], 2'b00, ~c};
      OP_SCF: fo = {f[FlagZ], 2'b00, 1'b1};
      default: wr = 1'b0;
    endcase
  end

  assign res_o = '{result: r, flags: fo, wr: wr};

endmodule

// ----- sv/eight_bit_cpu_alu_with_flags.sv -----
// Path: an input transfer passes through the input register, then the result
//   register, where the result may wait on out_ready_i.
// Throughput: one operation per cycle; both stages advance together whenever
//   the result register is empty or being drained.
// Reset: rst_ni clears both stage valid bits; payload registers are not reset.
module eight_bit_cpu_alu_with_flags
  import alu8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [DataW-1:0] accumulator_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic [BitW-1:0]  bit_index_i,
  input  logic [FlagW-1:0] flags_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] result_o,
  output logic [FlagW-1:0] flags_out_o,
  output logic             write_result_o
);

  logic     req_valid_q, req_valid_d;
  alu_req_t req_q;
  logic     res_valid_q, res_valid_d;
  alu_res_t res_q, res_d;
  logic     res_ready, req_ready;

  // Each stage accepts when empty or when its contents move on
  assign res_ready  = !res_valid_q || out_ready_i;
  assign req_ready  = !req_valid_q || res_ready;
  assign in_ready_o = req_ready;

  assign req_valid_d = in_valid_i || (req_valid_q && !res_ready);
  assign res_valid_d = req_valid_q || (res_valid_q && !out_ready_i);

  // Hold the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (req_ready) req_valid_q <= req_valid_d;
      if (res_ready) res_valid_q <= res_valid_d;
    end
  end

  // Capture the operation on an input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && req_ready) begin
      req_q <= '{op: op_i, acc: accumulator_i, opb: operand_b_i,
                 bit_idx: bit_index_i, flags: flags_in_i};
    end
  end

  alu8_core u_core (
    .req_i (req_q),
    .res_o (res_d)
  );

  // Advance the result into the output register
  always_ff @(posedge clk_i) begin
    if (req_valid_q && res_ready) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign result_o       = res_q.result;
  assign flags_out_o    = res_q.flags;
  assign write_result_o = res_q.wr;

endmodule

// ----- sv/alu8_checker.sv -----
module alu8_checker
  import alu8_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [OpW-1:0]   op_i,
  input logic [DataW-1:0] accumulator_i,
  input logic [DataW-1:0] operand_b_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DataW-1:0] result_o,
  input logic [FlagW-1:0] flags_out_o,
  input logic             write_result_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o)
      && $stable(flags_out_o) && $stable(write_result_o))
    else $error("stalled result changed");

  // An empty output never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A transfer reaches the output when the sink is ready while it sits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after two cycles");

  // Check xor data end to end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == OP_XOR)) ##1 out_ready_i |=>
      (result_o == ($past(accumulator_i, 2) ^ $past(operand_b_i, 2)))
      && write_result_o)
    else $error("xor result mismatch");

endmodule

bind eight_bit_cpu_alu_with_flags alu8_checker u_alu8_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .accumulator_i  (accumulator_i),
  .operand_b_i    (operand_b_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_o       (result_o),
  .flags_out_o    (flags_out_o),
  .write_result_o (write_result_o)
);
